>>> hw/rtl/homogeneous_vector_alu_unit_macros.svh
// Assertion helpers shared by the vector ALU sources.
// Each macro is evaluated on the rising edge of clk and is
// switched off while rst is high.
`ifndef HOMOGENEOUS_VECTOR_ALU_UNIT_MACROS_SVH
`define HOMOGENEOUS_VECTOR_ALU_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HVAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HVAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hvau_pkg.sv
package hvau_pkg;

  localparam logic [3:0] CMD_EQUAL     = 4'd0;
  localparam logic [3:0] CMD_ADD       = 4'd1;
  localparam logic [3:0] CMD_SUB       = 4'd2;
  localparam logic [3:0] CMD_NEGATE    = 4'd3;
  localparam logic [3:0] CMD_SCALE     = 4'd4;
  localparam logic [3:0] CMD_DIVIDE    = 4'd5;
  localparam logic [3:0] CMD_MAGNITUDE = 4'd6;
  localparam logic [3:0] CMD_NORMALIZE = 4'd7;
  localparam logic [3:0] CMD_DOT       = 4'd8;
  localparam logic [3:0] CMD_CROSS     = 4'd9;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OPND = 2'd2;

  // Register index taken from the word address.
  localparam logic REG_EQUAL_TOL = 1'b0;

  // One result bit of the square root per stage.
  localparam int SQRT_LAT = 32;
  // One quotient bit per stage, plus a setup stage.
  localparam int DIV_ITER = 32;
  localparam int DIV_LAT  = DIV_ITER + 1;
  localparam int PIPE_DEPTH = SQRT_LAT + DIV_LAT;

  // Everything a request carries along the long pipeline.
  typedef struct packed {
    logic [3:0]       cmd;
    logic [3:0][31:0] a;
    logic [31:0]      sc;
    logic [3:0][31:0] r;
    logic [31:0]      rs;
    logic             eq;
    logic [1:0]       status;
  } side_t;

  // Saturates a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat66(input logic signed [65:0] v);
    if ((&v[65:31]) || !(|v[65:31])) begin
      return v[31:0];
    end
    return v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

endpackage

>>> hw/rtl/hvau_lane.sv
module hvau_lane import hvau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic [31:0]        m1a,
  input  logic [31:0]        m1b,
  input  logic [31:0]        m2a,
  input  logic [31:0]        m2b,
  output logic signed [63:0] p1,
  output logic [31:0]        res
);

  logic signed [63:0] p2;
  logic signed [64:0] diff;

  always_ff @(posedge clk) begin
    p1 <= 64'($signed(m1a)) * 64'($signed(m1b));
    p2 <= 64'($signed(m2a)) * 64'($signed(m2b));
  end

  // The shift floors the exact difference before saturation.
  assign diff = 65'(p1) - 65'(p2);
  assign res  = sat66(66'(diff >>> FRAC_BITS));

endmodule

>>> hw/rtl/hvau_merge.sv
module hvau_merge import hvau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  side_t            s1,
  input  logic [2:0][63:0] prod,
  input  logic [3:0][31:0] lane_res,
  output side_t            s2,
  output logic [63:0]      mag_sq
);

  logic signed [65:0] sum;
  side_t nx;

  always_comb begin
    sum = 66'($signed(prod[0])) + 66'($signed(prod[1])) + 66'($signed(prod[2]));
    nx = s1;
    case (s1.cmd)
      CMD_SCALE: begin
        nx.r = lane_res;
      end
      CMD_DOT: begin
        if (s1.status == ST_OK) begin
          nx.rs = sat66(sum >>> FRAC_BITS);
        end
      end
      CMD_CROSS: begin
        if (s1.status == ST_OK) begin
          nx.r    = lane_res;
          nx.r[3] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s2     <= nx;
    mag_sq <= sum[63:0];
  end

endmodule

>>> hw/rtl/hvau_sqrt.sv
module hvau_sqrt import hvau_pkg::*; (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [63:0] xs  [SQRT_LAT];
  logic [34:0] rem [SQRT_LAT];
  logic [31:0] rt  [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [63:0] x_in;
    logic [34:0] r_in;
    logic [31:0] q_in;
    logic [34:0] r_sh;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign x_in = radicand;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign x_in = xs[k-1];
      assign r_in = rem[k-1];
      assign q_in = rt[k-1];
    end

    assign r_sh  = {r_in[32:0], x_in[63:62]};
    assign trial = {1'b0, q_in, 2'b01};

    always_ff @(posedge clk) begin
      xs[k] <= {x_in[61:0], 2'b00};
      if (r_sh >= trial) begin
        rem[k] <= r_sh - trial;
        rt[k]  <= {q_in[30:0], 1'b1};
      end else begin
        rem[k] <= r_sh;
        rt[k]  <= {q_in[30:0], 1'b0};
      end
    end
  end

  assign root = rt[SQRT_LAT-1];

endmodule

>>> hw/rtl/hvau_div.sv
module hvau_div import hvau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic [31:0] numer,
  input  logic [31:0] dmag,
  input  logic        neg,
  output logic [31:0] quo
);

  localparam int NW = 32 + FRAC_BITS;

  logic [31:0]   nmag;
  logic [NW-1:0] nsh;
  logic [31:0]   rem [DIV_ITER+1];
  logic [31:0]   lo  [DIV_ITER+1];
  logic [31:0]   dv  [DIV_ITER+1];
  logic          ovf [DIV_ITER+1];
  logic          ng  [DIV_ITER+1];
  logic [31:0]   q;
  logic          big;

  assign nmag = numer[31] ? (~numer + 32'd1) : numer;
  assign nsh  = {nmag, {FRAC_BITS{1'b0}}};

  // The upper bits start the remainder; if they already reach the divisor
  // the quotient needs more than 32 bits and saturates.
  always_ff @(posedge clk) begin
    rem[0] <= 32'(nsh[NW-1:32]);
    lo[0]  <= nsh[31:0];
    dv[0]  <= dmag;
    ovf[0] <= 32'(nsh[NW-1:32]) >= dmag;
    ng[0]  <= neg;
  end

  for (genvar k = 1; k <= DIV_ITER; k++) begin : g_iter
    logic [32:0] r_sh;
    logic        take;

    assign r_sh = {rem[k-1], lo[k-1][31]};
    assign take = r_sh >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      rem[k] <= take ? 32'(r_sh - {1'b0, dv[k-1]}) : r_sh[31:0];
      lo[k]  <= {lo[k-1][30:0], take};
      dv[k]  <= dv[k-1];
      ovf[k] <= ovf[k-1];
      ng[k]  <= ng[k-1];
    end
  end

  assign q   = lo[DIV_ITER];
  assign big = ovf[DIV_ITER] | q[31];

  always_comb begin
    if (big) begin
      quo = ng[DIV_ITER] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      quo = ng[DIV_ITER] ? (~q + 32'd1) : q;
    end
  end

endmodule

>>> hw/rtl/homogeneous_vector_alu_unit.sv
// Pipeline: an accepted request passes 3 front stages, 32 square-root stages,
// 33 divider stages and the output register, where done rises.
// Throughput: one request per cycle; busy is low whenever rst is low.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst, synchronous, active high) empties the pipeline and sets the
// equality tolerance to 7.
module homogeneous_vector_alu_unit import hvau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         command,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] a_w,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] b_w,
  input  logic signed [31:0] scalar_in,
  output logic               done,
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic signed [31:0] r_z,
  output logic signed [31:0] r_w,
  output logic signed [31:0] r_scalar,
  output logic               is_equal,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

`include "homogeneous_vector_alu_unit_macros.svh"

  // Number of edges between the accepting edge and the edge at which the
  // result is taken, as seen by a sampled property.
  localparam int OUT_LAT = PIPE_DEPTH + 4;

  // Configuration register. The user must write it only while the unit is
  // idle; the block does not enforce it. Stage 1 compares against it directly.
  logic [15:0] equal_tolerance;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_EQUAL_TOL) ? {16'd0, equal_tolerance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      equal_tolerance <= 16'd7;
    end else if (cfg_wr && paddr[2] == REG_EQUAL_TOL) begin
      equal_tolerance <= pwdata[15:0];
    end
  end

  // The pipeline never pushes back, so a request is refused only in reset.
  assign busy = rst;

  // Stage 0: the request is registered as it arrives.
  logic             v0;
  logic [3:0]       cmd0;
  logic [3:0][31:0] a0;
  logic [3:0][31:0] b0;
  logic [31:0]      sc0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start & ~busy;
    end
    cmd0 <= command;
    a0   <= {a_w, a_z, a_y, a_x};
    b0   <= {b_w, b_z, b_y, b_x};
    sc0  <= scalar_in;
  end

  // Stage 1: add, subtract, negate and equal finish here, the status checks
  // that need only the operands are made, and each lane's multiplier operands
  // are chosen. Lanes 0 to 2 hold x, y and z, lane 3 holds w.
  side_t              s1_next;
  side_t              s1;
  logic               v1;
  logic [3:0][31:0]   m1a;
  logic [3:0][31:0]   m1b;
  logic [3:0][31:0]   m2a;
  logic [3:0][31:0]   m2b;
  logic               eq_v;
  logic               wnz;
  logic signed [65:0] dif;
  logic signed [65:0] adif;

  always_comb begin
    s1_next        = '0;
    s1_next.cmd    = cmd0;
    s1_next.a      = a0;
    s1_next.sc     = sc0;
    s1_next.status = ST_OK;
    m1a            = '0;
    m1b            = '0;
    m2a            = '0;
    m2b            = '0;
    dif            = '0;
    adif           = '0;

    // The w components must match exactly; x, y and z within the tolerance.
    eq_v = (a0[3] == b0[3]);
    for (int i = 0; i < 3; i++) begin
      dif  = 66'($signed(a0[i])) - 66'($signed(b0[i]));
      adif = dif[65] ? -dif : dif;
      if (adif >= 66'(equal_tolerance)) begin
        eq_v = 1'b0;
      end
    end

    wnz = (a0[3] != '0) || (b0[3] != '0);

    case (cmd0)
      CMD_EQUAL: begin
        s1_next.eq = eq_v;
      end
      CMD_ADD: begin
        for (int i = 0; i < 4; i++) begin
          s1_next.r[i] = sat66(66'($signed(a0[i])) + 66'($signed(b0[i])));
        end
      end
      CMD_SUB: begin
        for (int i = 0; i < 4; i++) begin
          s1_next.r[i] = sat66(66'($signed(a0[i])) - 66'($signed(b0[i])));
        end
      end
      CMD_NEGATE: begin
        for (int i = 0; i < 4; i++) begin
          s1_next.r[i] = sat66(66'sd0 - 66'($signed(a0[i])));
        end
      end
      CMD_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          m1a[i] = a0[i];
          m1b[i] = sc0;
        end
      end
      CMD_DIVIDE: begin
        if (sc0 == '0) begin
          s1_next.status = ST_DIVZ;
        end
      end
      CMD_MAGNITUDE, CMD_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          m1a[i] = a0[i];
          m1b[i] = a0[i];
        end
      end
      CMD_DOT: begin
        if (wnz) begin
          s1_next.status = ST_OPND;
        end else begin
          for (int i = 0; i < 3; i++) begin
            m1a[i] = a0[i];
            m1b[i] = b0[i];
          end
        end
      end
      CMD_CROSS: begin
        if (wnz) begin
          s1_next.status = ST_OPND;
        end else begin
          // x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
          m1a[0] = a0[1]; m1b[0] = b0[2]; m2a[0] = a0[2]; m2b[0] = b0[1];
          m1a[1] = a0[2]; m1b[1] = b0[0]; m2a[1] = a0[0]; m2b[1] = b0[2];
          m1a[2] = a0[0]; m1b[2] = b0[1]; m2a[2] = a0[1]; m2b[2] = b0[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    s1 <= s1_next;
  end

  // The four lanes register their products alongside stage 1 and hand back
  // the floored, saturated lane result for scale and cross.
  logic [3:0][63:0] prod;
  logic [3:0][31:0] lane_res;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    hvau_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk(clk),
      .m1a(m1a[i]),
      .m1b(m1b[i]),
      .m2a(m2a[i]),
      .m2b(m2b[i]),
      .p1 (prod[i]),
      .res(lane_res[i])
    );
  end

  // Stage 2: the merge adds the x, y and z products for dot, magnitude and
  // normalize, and settles every result that does not need a root or a quotient.
  side_t       s2;
  logic [63:0] mag_sq;
  logic        v2;

  hvau_merge #(
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk     (clk),
    .s1      (s1),
    .prod    (prod[2:0]),
    .lane_res(lane_res),
    .s2      (s2),
    .mag_sq  (mag_sq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // The square root and the dividers form one long pipeline. Every request
  // walks its full length so that results leave in order at a fixed latency;
  // the request's own data rides in side_pipe next to it.
  logic [31:0]           root;
  side_t                 side_pipe [PIPE_DEPTH];
  logic [PIPE_DEPTH-1:0] vpipe;
  side_t                 side_mid;
  logic [31:0]           sc_mag;
  logic                  is_div;
  logic [31:0]           dmag;
  logic [3:0][31:0]      quo;

  hvau_sqrt u_sqrt (
    .clk     (clk),
    .radicand(mag_sq),
    .root    (root)
  );

  // Where the root comes out, the magnitude result is written and a zero
  // length turns a normalize request into a divide-by-zero.
  always_comb begin
    side_mid = side_pipe[SQRT_LAT-1];
    case (side_pipe[SQRT_LAT-1].cmd)
      CMD_MAGNITUDE: begin
        side_mid.rs = root[31] ? 32'h7FFF_FFFF : root;
      end
      CMD_NORMALIZE: begin
        if (root == '0) begin
          side_mid.status = ST_DIVZ;
        end
      end
      default: begin
      end
    endcase
  end

  // Divide uses the magnitude of the scalar; normalize uses the root, which
  // is positive, so only the numerator's sign matters there.
  assign is_div = (side_pipe[SQRT_LAT-1].cmd == CMD_DIVIDE);
  assign sc_mag = side_pipe[SQRT_LAT-1].sc[31] ? (~side_pipe[SQRT_LAT-1].sc + 32'd1)
                                               : side_pipe[SQRT_LAT-1].sc;
  assign dmag   = is_div ? sc_mag : root;

  for (genvar i = 0; i < 4; i++) begin : g_div
    hvau_div #(
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk  (clk),
      .numer(side_pipe[SQRT_LAT-1].a[i]),
      .dmag (dmag),
      .neg  (side_pipe[SQRT_LAT-1].a[i][31] ^ (is_div & side_pipe[SQRT_LAT-1].sc[31])),
      .quo  (quo[i])
    );
  end

  for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_side
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        side_pipe[k] <= s2;
      end
    end else if (k == SQRT_LAT) begin : g_mid
      always_ff @(posedge clk) begin
        side_pipe[k] <= side_mid;
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        side_pipe[k] <= side_pipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[PIPE_DEPTH-2:0], v2};
    end
  end

  // Output register: quotients replace the tuple for a divide or normalize
  // that passed its checks; any error leaves the all-zero result.
  side_t fin;
  logic  use_quo;

  assign fin     = side_pipe[PIPE_DEPTH-1];
  assign use_quo = ((fin.cmd == CMD_DIVIDE) || (fin.cmd == CMD_NORMALIZE)) &&
                   (fin.status == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vpipe[PIPE_DEPTH-1];
    end
    r_x      <= $signed(use_quo ? quo[0] : fin.r[0]);
    r_y      <= $signed(use_quo ? quo[1] : fin.r[1]);
    r_z      <= $signed(use_quo ? quo[2] : fin.r[2]);
    r_w      <= $signed(use_quo ? quo[3] : fin.r[3]);
    r_scalar <= $signed(fin.rs);
    is_equal <= fin.eq;
    status   <= fin.status;
  end

  // A result appears only at the fixed latency after an accepted request.
  `HVAU_ASSERT_SAME(a_done_latency, done, $past(start && !busy, OUT_LAT), "result without request")
  // Any error status comes with an all-zero result.
  `HVAU_ASSERT_SAME(a_err_zero, done && status != ST_OK, r_x == 0 && r_y == 0 && r_z == 0 && r_w == 0 && r_scalar == 0, "error result not zero")
  // A zero-length normalize is flagged once the root is known.
  `HVAU_ASSERT_NEXT(a_norm_divz, vpipe[SQRT_LAT-1] && side_pipe[SQRT_LAT-1].cmd == CMD_NORMALIZE && root == 32'd0, side_pipe[SQRT_LAT].status == ST_DIVZ, "zero length not flagged")

endmodule
